// ----- rtl/core/cpf_pkg.sv -----
// shared types, step codes and crc helper for the packet framer
`timescale 1ns / 1ps
`default_nettype none

package cpf_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [7:0]  HDR_BYTE_A = 8'hFF;
  localparam logic [7:0]  HDR_BYTE_B = 8'hFD;
  localparam logic [7:0]  HDR_BYTE_C = 8'h00;
  localparam logic [15:0] LEN_EXTRA  = 16'd3;

  // byte positions within one item's run of output bytes
  localparam logic [3:0] STEP_HDR0    = 4'd0;
  localparam logic [3:0] STEP_HDR1    = 4'd1;
  localparam logic [3:0] STEP_HDR2    = 4'd2;
  localparam logic [3:0] STEP_HDR3    = 4'd3;
  localparam logic [3:0] STEP_ID      = 4'd4;
  localparam logic [3:0] STEP_LEN_LO  = 4'd5;
  localparam logic [3:0] STEP_LEN_HI  = 4'd6;
  localparam logic [3:0] STEP_INSTR   = 4'd7;
  localparam logic [3:0] STEP_PARAM   = 4'd8;
  localparam logic [3:0] STEP_CRC_LO  = 4'd9;
  localparam logic [3:0] STEP_CRC_HI  = 4'd10;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  device_id;
    logic [7:0]  instr_code;
    logic [15:0] param_count;
    logic [7:0]  param_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  device_id;
    logic [7:0]  instr_code;
    logic [15:0] frame_len;
    logic [7:0]  param_byte;
  } cmd_t;

  // crc-16 update by one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cpf_front.sv -----
// front end: takes input items, works out the frame length, queues commands
`timescale 1ns / 1ps
`default_nettype none

module cpf_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire cpf_pkg::in_item_t in_item,
  output logic                  head_valid,
  output cpf_pkg::cmd_t         head_cmd,
  input  wire logic             pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cpf_pkg::cmd_t    queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             push;
  cpf_pkg::cmd_t    new_cmd;

  assign in_stall   = (count == CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != '0);
  assign head_cmd   = queue[rd_ptr];

  always_comb begin
    new_cmd.first      = in_item.first;
    new_cmd.last       = in_item.last;
    new_cmd.device_id  = in_item.device_id;
    new_cmd.instr_code = in_item.instr_code;
    new_cmd.frame_len  = in_item.param_count + cpf_pkg::LEN_EXTRA;
    new_cmd.param_byte = in_item.param_byte;
  end

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_cmd;
    end
  end

`ifndef SYNTH
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue count mismatch");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/cpf_back.sv -----
// back end: walks each queued command byte by byte, keeps the crc, drives the output
`timescale 1ns / 1ps
`default_nettype none

module cpf_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  wire cpf_pkg::cmd_t      head_cmd,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cpf_pkg::out_item_t      out_item
);

  logic        in_prog;
  logic [3:0]  step;
  logic [15:0] crc;
  logic [3:0]  cur_step;
  logic [3:0]  end_step;
  logic [7:0]  cur_byte;
  logic [15:0] crc_in;
  logic [15:0] crc_upd;
  logic        advance;
  logic        run_done;

  assign advance  = head_valid && (!out_valid || !out_stall);
  assign cur_step = in_prog ? step : (head_cmd.first ? cpf_pkg::STEP_HDR0 : cpf_pkg::STEP_PARAM);
  assign end_step = head_cmd.last ? cpf_pkg::STEP_CRC_HI : cpf_pkg::STEP_PARAM;
  assign run_done = (cur_step == end_step);
  assign pop      = advance && run_done;

  always_comb begin
    unique case (cur_step)
      cpf_pkg::STEP_HDR0:   cur_byte = cpf_pkg::HDR_BYTE_A;
      cpf_pkg::STEP_HDR1:   cur_byte = cpf_pkg::HDR_BYTE_A;
      cpf_pkg::STEP_HDR2:   cur_byte = cpf_pkg::HDR_BYTE_B;
      cpf_pkg::STEP_HDR3:   cur_byte = cpf_pkg::HDR_BYTE_C;
      cpf_pkg::STEP_ID:     cur_byte = head_cmd.device_id;
      cpf_pkg::STEP_LEN_LO: cur_byte = head_cmd.frame_len[7:0];
      cpf_pkg::STEP_LEN_HI: cur_byte = head_cmd.frame_len[15:8];
      cpf_pkg::STEP_INSTR:  cur_byte = head_cmd.instr_code;
      cpf_pkg::STEP_PARAM:  cur_byte = head_cmd.param_byte;
      cpf_pkg::STEP_CRC_LO: cur_byte = crc[7:0];
      cpf_pkg::STEP_CRC_HI: cur_byte = crc[15:8];
      default:              cur_byte = head_cmd.param_byte;
    endcase
  end

  // a new packet restarts the crc at its first header byte
  assign crc_in  = (cur_step == cpf_pkg::STEP_HDR0) ? '0 : crc;
  assign crc_upd = cpf_pkg::crc_byte(crc_in, cur_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_prog   <= 1'b0;
      step      <= cpf_pkg::STEP_HDR0;
      crc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (run_done) begin
          in_prog <= 1'b0;
        end else begin
          in_prog <= 1'b1;
          step    <= cur_step + 1'b1;
        end
        if (cur_step <= cpf_pkg::STEP_PARAM) begin
          crc <= crc_upd;
        end else if (cur_step == cpf_pkg::STEP_CRC_HI) begin
          crc <= '0;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.tx_byte   <= cur_byte;
      out_item.run_last  <= run_done;
      out_item.frame_end <= (cur_step == cpf_pkg::STEP_CRC_HI);
    end
  end

`ifndef SYNTH
  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.frame_end |-> out_item.run_last)
    else $error("frame end without run end");
  a_run_holds_head: assert property (@(posedge clk) disable iff (rst)
    in_prog |-> head_valid) else $error("command left queue mid run");
  a_crc_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && cur_step == cpf_pkg::STEP_CRC_HI |=> crc == '0)
    else $error("crc not cleared after frame");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    in_prog |-> step <= cpf_pkg::STEP_CRC_HI) else $error("step out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/crc16_packet_framer_top.sv -----
// top level: packet framer with queued front end and byte sequencer back end
// first output byte of an item passes the command queue, then the back end's output register
// throughput: one byte per unstalled cycle; an item is 1 byte, plus 8 with first, plus 2 with last
// the byte rate is set by the back end's single output register, one byte per unstalled cycle
// input accepts while the command queue (QUEUE_DEPTH entries) has room
// reset: synchronous; empties the queue, clears the sequencer, crc and output valid
`timescale 1ns / 1ps
`default_nettype none

module crc16_packet_framer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cpf_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cpf_pkg::out_item_t      out_item
);

  logic          head_valid;
  cpf_pkg::cmd_t head_cmd;
  logic          pop;

  cpf_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  cpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ----- dv/crc16_packet_framer_checker.sv -----
// framer checker: predicts the framed byte stream from accepted items and compares it
`timescale 1ns / 1ps
`default_nettype none

module crc16_packet_framer_checker
  import cpf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_item,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_item,
  output int             mismatches,
  output int             pending
);

  out_item_t   tx_bytes_q[$];
  logic [15:0] frame_crc;
  int          err_cnt;

  initial begin
    frame_crc = 16'h0000;
    err_cnt   = 0;
  end

  // bitwise crc-16 update, polynomial 0x8005, msb first
  function automatic logic [15:0] crc_shift_in(logic [15:0] acc, logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // works out every byte one item puts on the wire and queues them
  task automatic frame_item(in_item_t it);
    out_item_t   run[$];
    logic [7:0]  wire_bytes[$];
    logic [15:0] len;
    logic [15:0] crc_out;
    out_item_t   b;
    len = it.param_count + LEN_EXTRA;
    if (it.first) begin
      frame_crc = 16'h0000;
      wire_bytes = '{HDR_BYTE_A, HDR_BYTE_A, HDR_BYTE_B, HDR_BYTE_C, it.device_id,
                     len[7:0], len[15:8], it.instr_code};
    end
    wire_bytes.push_back(it.param_byte);
    foreach (wire_bytes[i]) begin
      frame_crc   = crc_shift_in(frame_crc, wire_bytes[i]);
      b.tx_byte   = wire_bytes[i];
      b.run_last  = 1'b0;
      b.frame_end = 1'b0;
      run.push_back(b);
    end
    if (it.last) begin
      crc_out     = frame_crc;
      b.tx_byte   = crc_out[7:0];
      b.frame_end = 1'b0;
      run.push_back(b);
      b.tx_byte   = crc_out[15:8];
      b.frame_end = 1'b1;
      run.push_back(b);
      frame_crc   = 16'h0000;
    end
    run[run.size() - 1].run_last = 1'b1;
    foreach (run[i]) tx_bytes_q.push_back(run[i]);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      tx_bytes_q.delete();
      frame_crc = 16'h0000;
      pending  <= 0;
    end else begin
      // outputs first: a byte can never belong to an item taken at the same edge
      if (out_valid && !out_stall) begin
        if (tx_bytes_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected byte %h run_last %b frame_end %b", $realtime,
                     out_item.tx_byte, out_item.run_last, out_item.frame_end);
        end else begin
          want = tx_bytes_q.pop_front();
          if (want.tx_byte !== out_item.tx_byte || want.run_last !== out_item.run_last ||
              want.frame_end !== out_item.frame_end) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: byte mismatch exp %h/%b/%b got %h/%b/%b", $realtime,
                       want.tx_byte, want.run_last, want.frame_end,
                       out_item.tx_byte, out_item.run_last, out_item.frame_end);
          end
        end
      end
      if (in_valid && !in_stall) frame_item(in_item);
      pending <= tx_bytes_q.size();
    end
    mismatches <= err_cnt;
  end

endmodule

`default_nettype wire

// ----- dv/crc16_packet_framer_top_tb.sv -----
// testbench top: clock, reset, item stimulus, stall patterns and verdict for the framer
`timescale 1ns / 1ps
`default_nettype none

module crc16_packet_framer_top_tb;
  import cpf_pkg::*;

  localparam int RANDOM_ITEMS   = 155;
  localparam int LONG_HOLD      = 120;
  localparam int WATCHDOG_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        mismatches;
  int        pending;
  logic      quiet;
  logic      hold_req;
  int        stuck_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  crc16_packet_framer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  crc16_packet_framer_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending)
  );

  function automatic in_item_t mk_item(logic f, logic l, logic [7:0] id, logic [7:0] ins,
                                       logic [15:0] cnt, logic [7:0] pb);
    in_item_t it;
    it.first       = f;
    it.last        = l;
    it.device_id   = id;
    it.instr_code  = ins;
    it.param_count = cnt;
    it.param_byte  = pb;
    return it;
  endfunction

  // offers one item and holds it until taken, then maybe goes idle for a burst
  task automatic send_item(in_item_t it);
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // receiver side: random stall bursts, one long hold-off, free stretches
  initial begin : rx_side
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // nothing accepted on either side for too long ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_item_t    it;
    int          sent;
    int          plen;
    logic [15:0] cnt;
    logic [7:0]  id;
    logic [7:0]  ins;
    bit          drained;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_item  <= '0;
    quiet    <= 1'b0;
    hold_req <= 1'b0;
    drained  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // no open packet after reset: bare parameter bytes, then a crc on them alone
    send_item(mk_item(1'b0, 1'b0, 8'h5A, 8'hA5, 16'h1234, 8'h00));
    send_item(mk_item(1'b0, 1'b1, 8'h00, 8'h00, 16'h0000, 8'hFF));
    // first and last together, field extremes, length wrap
    send_item(mk_item(1'b1, 1'b1, 8'h00, 8'h00, 16'd1, 8'h00));
    send_item(mk_item(1'b1, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF));
    send_item(mk_item(1'b1, 1'b1, 8'h01, 8'd2, 16'd65532, 8'h80));
    send_item(mk_item(1'b1, 1'b1, 8'hFE, 8'd3, 16'd65533, 8'h7F));
    send_item(mk_item(1'b1, 1'b1, 8'h42, 8'd3, 16'd0, 8'h01));
    // ordinary four byte write
    send_item(mk_item(1'b1, 1'b0, 8'h0A, 8'd3, 16'd4, 8'h11));
    send_item(mk_item(1'b0, 1'b0, 8'hFF, 8'hFF, 16'hFFFF, 8'h22));
    send_item(mk_item(1'b0, 1'b0, 8'h00, 8'h00, 16'h0000, 8'h33));
    send_item(mk_item(1'b0, 1'b1, 8'hAA, 8'h55, 16'h8000, 8'h44));
    // restart in the middle of a packet, count not matching
    send_item(mk_item(1'b1, 1'b0, 8'h07, 8'd2, 16'd3, 8'hC3));
    send_item(mk_item(1'b1, 1'b0, 8'h08, 8'd2, 16'd2, 8'h3C));
    send_item(mk_item(1'b0, 1'b1, 8'h00, 8'h00, 16'd0, 8'h96));
    // bytes after a finished packet
    send_item(mk_item(1'b0, 1'b0, 8'h12, 8'h34, 16'h5678, 8'h69));
    send_item(mk_item(1'b0, 1'b1, 8'h87, 8'h65, 16'h4321, 8'hA5));

    hold_req <= 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // once midway, wait for every expected byte before going on
      if (!drained && sent >= 70) begin
        wait_drained();
        drained = 1'b1;
      end
      if (sent >= RANDOM_ITEMS - 30) quiet <= 1'b1;
      if ($urandom_range(0, 9) < 8) begin
        plen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        cnt  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(plen);
        id   = 8'($urandom);
        case ($urandom_range(0, 2))
          0:       ins = 8'd2;
          1:       ins = 8'd3;
          default: ins = 8'($urandom);
        endcase
        for (int k = 0; k < plen; k++) begin
          if (k == 0) begin
            it = mk_item(1'b1, plen == 1, id, ins, cnt, 8'($urandom));
          end else begin
            it = mk_item(1'b0, k == plen - 1, 8'($urandom), 8'($urandom), 16'($urandom),
                         8'($urandom));
          end
          send_item(it);
          sent++;
        end
      end else begin
        send_item(mk_item(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom), 8'($urandom)));
        sent++;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
